// ===== rtl/lpnal_pkg.sv =====
// Shared types, constants and helper functions for the length-prefixed NAL
// to Annex B converter. Used by lpnal_parser and the top-level unit.
// No dependencies.
package lpnal_pkg;

   // Largest packet the block accepts. A longer packet is flagged as an error.
   localparam int MAX_PACKET_BYTES = 1048576;

   localparam int DATA_WIDTH   = 8;
   localparam int PLEN_WIDTH   = 21;
   localparam int COUNT_WIDTH  = 22;
   localparam int LFB_WIDTH    = 3;
   localparam int ACC_WIDTH    = 32;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam int IDX_WIDTH    = 2;
   localparam int NRES_WIDTH   = 3;

   // Annex B start code, sent least significant byte first: 00 00 00 01.
   localparam logic [31:0] START_CODE = 32'h0100_0000;

   localparam logic [LFB_WIDTH-1:0] LFB_RESET = 3'd4;
   localparam logic [LFB_WIDTH-1:0] LFB_MAX   = 3'd4;

   // Register index of length_field_bytes in the configuration space.
   localparam logic REG_LFB = 1'b0;

   // What one transaction asks the output side to send, ahead of the status.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_PAYLOAD,
      KIND_START
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [DATA_WIDTH-1:0]    data;
      logic                     pkt_end;
      logic                     pkt_err;
      logic [COUNT_WIDTH-1:0]   count;
   } desc_type;

   // Number of bytes a result kind puts on the output.
   function automatic logic [NRES_WIDTH-1:0] kind_bytes(input kind_type kind);
      logic [NRES_WIDTH-1:0] n;
      case (kind)
         KIND_PAYLOAD: n = 3'd1;
         KIND_START:   n = 3'd4;
         default:      n = 3'd0;
      endcase
      return n;
   endfunction

   // Number of result transactions for one descriptor, status included.
   function automatic logic [NRES_WIDTH-1:0] result_count(input desc_type d);
      return kind_bytes(d.kind) + NRES_WIDTH'(d.pkt_end);
   endfunction

   // Byte i of the start code in output order.
   function automatic logic [DATA_WIDTH-1:0] start_code_byte(input logic [IDX_WIDTH-1:0] i);
      return START_CODE[8*i +: 8];
   endfunction

endpackage

// ===== rtl/lpnal_parser.sv =====
// Packet parser: holds the per-packet state and works out, for each accepted
// input transaction, the next state and a descriptor of the results it causes.
// Depends on lpnal_pkg.
module lpnal_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [lpnal_pkg::DATA_WIDTH-1:0]     data_byte,
   input  logic [lpnal_pkg::PLEN_WIDTH-1:0]     packet_length,
   input  logic [lpnal_pkg::LFB_WIDTH-1:0]      length_field_bytes,
   output lpnal_pkg::desc_type                  desc
);
   import lpnal_pkg::*;

   typedef enum logic {
      PH_LEN,
      PH_PAY
   } phase_type;

   phase_type               phase_ff,    phase_in;
   logic [ACC_WIDTH-1:0]    acc_ff,      acc_in;
   logic [LFB_WIDTH-1:0]    seen_ff,     seen_in;
   logic [PLEN_WIDTH-1:0]   rem_ff,      rem_in;
   logic [PLEN_WIDTH-1:0]   consumed_ff, consumed_in;
   logic [PLEN_WIDTH-1:0]   total_ff,    total_in;
   logic [COUNT_WIDTH-1:0]  emitted_ff,  emitted_in;
   logic                    err_ff,      err_in;

   always_comb begin
      logic                   first;
      logic [PLEN_WIDTH-1:0]  plen;
      logic [PLEN_WIDTH-1:0]  total;
      logic [PLEN_WIDTH-1:0]  consumed;
      logic [PLEN_WIDTH-1:0]  left;
      logic [ACC_WIDTH-1:0]   acc;
      logic [ACC_WIDTH-1:0]   len;
      logic [LFB_WIDTH-1:0]   seen;
      logic [PLEN_WIDTH-1:0]  rem;
      logic [COUNT_WIDTH:0]   sum;
      logic [COUNT_WIDTH-1:0] emitted;
      logic                   err;
      logic                   pkt_end;
      phase_type              phase;
      kind_type               kind;

      // The first byte of a packet starts from a clean state.
      first = (consumed_ff == '0);
      plen  = (packet_length == '0) ? PLEN_WIDTH'(1) : packet_length;
      total = first ? plen : total_ff;
      phase = first ? PH_LEN : phase_ff;
      acc   = first ? '0 : acc_ff;
      seen  = first ? '0 : seen_ff;
      rem   = first ? '0 : rem_ff;
      emitted = first ? '0 : emitted_ff;
      err   = first ? 1'b0 : err_ff;
      len   = '0;
      left  = '0;
      kind  = KIND_NONE;

      if (first && (ACC_WIDTH'(total) > ACC_WIDTH'(MAX_PACKET_BYTES))) begin
         err = 1'b1;
      end
      if (length_field_bytes == '0 || length_field_bytes > LFB_MAX) begin
         err = 1'b1;
      end

      consumed = consumed_ff + PLEN_WIDTH'(consumed_ff < total);

      if (!err) begin
         if (phase == PH_PAY) begin
            kind = KIND_PAYLOAD;
            if (rem != '0) begin
               rem = rem - PLEN_WIDTH'(1);
            end
            if (rem == '0) begin
               phase = PH_LEN;
            end
         end else begin
            acc = {acc[ACC_WIDTH-DATA_WIDTH-1:0], data_byte};
            if (seen != '1) begin
               seen = seen + LFB_WIDTH'(1);
            end
            if (seen >= length_field_bytes) begin
               len  = acc;
               left = total - consumed;
               acc  = '0;
               seen = '0;
               if (len != '0) begin
                  if (len > ACC_WIDTH'(left)) begin
                     err = 1'b1;
                  end else begin
                     kind  = KIND_START;
                     rem   = len[PLEN_WIDTH-1:0];
                     phase = PH_PAY;
                  end
               end
            end
         end
      end

      // Byte count saturates at its full-scale value.
      sum     = {1'b0, emitted} + (COUNT_WIDTH+1)'(kind_bytes(kind));
      emitted = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

      pkt_end = (consumed >= total);
      if (pkt_end && !err && phase == PH_LEN && seen != '0) begin
         err = 1'b1;
      end

      desc.kind    = kind;
      desc.data    = data_byte;
      desc.pkt_end = pkt_end;
      desc.pkt_err = pkt_end & err;
      desc.count   = pkt_end ? emitted : '0;

      phase_in    = phase_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      rem_in      = rem_ff;
      consumed_in = consumed_ff;
      total_in    = total_ff;
      emitted_in  = emitted_ff;
      err_in      = err_ff;
      if (accept) begin
         if (pkt_end) begin
            phase_in    = PH_LEN;
            acc_in      = '0;
            seen_in     = '0;
            rem_in      = '0;
            consumed_in = '0;
            total_in    = '0;
            emitted_in  = '0;
            err_in      = 1'b0;
         end else begin
            phase_in    = phase;
            acc_in      = acc;
            seen_in     = seen;
            rem_in      = rem;
            consumed_in = consumed;
            total_in    = total;
            emitted_in  = emitted;
            err_in      = err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN;
         acc_ff      <= '0;
         seen_ff     <= '0;
         rem_ff      <= '0;
         consumed_ff <= '0;
         total_ff    <= '0;
         emitted_ff  <= '0;
         err_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         seen_ff     <= seen_in;
         rem_ff      <= rem_in;
         consumed_ff <= consumed_in;
         total_ff    <= total_in;
         emitted_ff  <= emitted_in;
         err_ff      <= err_in;
      end
   end

endmodule

// ===== rtl/length_prefixed_nal_to_annexb_unit.sv =====
// The first result of a transaction is offered in the cycle after it is accepted.
// One input byte per cycle while payload passes through and the receiver does not stall;
// a completed length field sends four start-code bytes, and the packet status follows them.
// The output sequencer offers one result per cycle and takes new input with its last result.
// Reset (synchronous, active high) clears all packet state and sets length_field_bytes to 4.
// Top level of the length-prefixed NAL to Annex B converter. Depends on lpnal_pkg, lpnal_parser.
module length_prefixed_nal_to_annexb_unit (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lpnal_pkg::DATA_WIDTH-1:0]     req_data_byte,
   input  logic [lpnal_pkg::PLEN_WIDTH-1:0]     req_packet_length,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lpnal_pkg::DATA_WIDTH-1:0]     rsp_out_byte,
   output logic                                 rsp_byte_valid,
   output logic                                 rsp_packet_end,
   output logic                                 rsp_packet_error,
   output logic [lpnal_pkg::COUNT_WIDTH-1:0]    rsp_output_count,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lpnal_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [lpnal_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [lpnal_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                 csr_pready
);
   import lpnal_pkg::*;

   // Configuration register. The word index is taken from paddr[2]; the low
   // address bits select a byte lane and are ignored.
   logic [LFB_WIDTH-1:0]  lfb_ff, lfb_in;
   logic                  csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      lfb_in = lfb_ff;
      if (csr_write && csr_paddr[2] == REG_LFB) begin
         lfb_in = csr_pwdata[LFB_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_LFB) begin
         csr_prdata = CSR_DW'(lfb_ff);
      end
   end

   // The parser sees each accepted transaction and describes the results it causes
   // in a single descriptor, which is captured in the pending register below if it causes any result.
   logic      accept;
   desc_type  desc;

   lpnal_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .data_byte          (req_data_byte),
      .packet_length      (req_packet_length),
      .length_field_bytes (lfb_ff),
      .desc               (desc)
   );

   // Pending descriptor and the index of the result being offered. A descriptor
   // yields its bytes first and then, if it closes the packet, the status result.
   logic                  pend_valid_ff, pend_valid_in;
   desc_type              pend_ff,       pend_in;
   logic [IDX_WIDTH-1:0]  idx_ff,        idx_in;
   logic [NRES_WIDTH-1:0] pend_bytes;
   logic [NRES_WIDTH-1:0] pend_nres;
   logic                  out_fire;
   logic                  out_last;
   logic                  is_byte;

   assign pend_bytes = kind_bytes(pend_ff.kind);
   assign pend_nres  = result_count(pend_ff);
   assign out_fire   = rsp_valid && rsp_ready;
   assign out_last   = out_fire && (NRES_WIDTH'(idx_ff) == pend_nres - NRES_WIDTH'(1));

   // A new transaction is taken whenever the pending register is free or is
   // handing over its last result in this cycle.
   assign req_ready  = !pend_valid_ff || out_last;
   assign accept     = req_valid && req_ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      if (out_fire) begin
         idx_in = idx_ff + IDX_WIDTH'(1);
      end
      if (out_last) begin
         pend_valid_in = 1'b0;
      end
      // Transactions that only advance a length field cause no result.
      if (accept && result_count(desc) != '0) begin
         pend_valid_in = 1'b1;
         pend_in       = desc;
         idx_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfb_ff        <= LFB_RESET;
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         lfb_ff        <= lfb_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
      end
      pend_ff <= pend_in;
   end

   // Result fields are selected from the pending descriptor by the result index.
   assign is_byte   = NRES_WIDTH'(idx_ff) < pend_bytes;
   assign rsp_valid = pend_valid_ff;

   always_comb begin
      rsp_out_byte     = '0;
      rsp_byte_valid   = is_byte;
      rsp_packet_end   = !is_byte;
      rsp_packet_error = !is_byte && pend_ff.pkt_err;
      rsp_output_count = is_byte ? '0 : pend_ff.count;
      if (is_byte) begin
         case (pend_ff.kind)
            KIND_PAYLOAD: rsp_out_byte = pend_ff.data;
            KIND_START:   rsp_out_byte = start_code_byte(idx_ff);
            default:      rsp_out_byte = '0;
         endcase
      end
   end

endmodule

// ===== rtl/lpnal_checker.sv =====
// Port-level checks for the length-prefixed NAL to Annex B converter, and the
// bind that attaches them to the top level. Depends on lpnal_pkg.
module lpnal_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [lpnal_pkg::DATA_WIDTH-1:0]     rsp_out_byte,
   input  logic                                 rsp_byte_valid,
   input  logic                                 rsp_packet_end,
   input  logic                                 rsp_packet_error,
   input  logic [lpnal_pkg::COUNT_WIDTH-1:0]    rsp_output_count
);
   import lpnal_pkg::*;

   // A stalled result transaction holds its contents.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
            $stable(rsp_byte_valid) && $stable(rsp_packet_end) &&
            $stable(rsp_packet_error) && $stable(rsp_output_count);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // Every result is either a byte or the packet status, never both.
   property p_kind_exclusive;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_byte_valid != rsp_packet_end);
   endproperty
   a_kind_exclusive: assert property (p_kind_exclusive)
      else $error("result is neither or both of byte and status");

   // Byte results carry no status information.
   property p_byte_no_status;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_byte_valid |-> rsp_output_count == '0 && !rsp_packet_error;
   endproperty
   a_byte_no_status: assert property (p_byte_no_status)
      else $error("status fields set on a byte result");

   // The input side only stalls while results are waiting to be taken.
   property p_no_idle_stall;
      @(posedge clock) disable iff (reset)
         !req_ready |-> rsp_valid;
   endproperty
   a_no_idle_stall: assert property (p_no_idle_stall)
      else $error("input stalled with no result pending");

endmodule

bind length_prefixed_nal_to_annexb_unit lpnal_checker u_lpnal_checker (.*);

// ===== verif/length_prefixed_nal_to_annexb_unit_tb.sv =====
// Self-checking testbench for length_prefixed_nal_to_annexb_unit: drives length-prefixed
// packets byte by byte, predicts the Annex B byte stream and packet status, and checks them.
// Depends on lpnal_pkg and the RTL of the unit; needs nothing else.
module length_prefixed_nal_to_annexb_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpnal_pkg::*;

   // The only register, length_field_bytes, sits at byte address 4 * index.
   localparam logic [CSR_AW-1:0] LFB_ADDR = CSR_AW'(4 * int'(REG_LFB));
   // Cycles to let pass once nothing is expected, since a byte that is dropped or that
   // only extends a length field produces no result but may still be in flight.
   localparam int IDLE_SETTLE = 8;
   // After this many input transactions the receiver goes quiet for a long stretch so that
   // the unit backs up and has to stall its input.
   localparam int HOLD_AFTER = 120;
   localparam int LONG_HOLD = 300;
   // The stimulus side stays at most this far ahead of the driver.
   localparam int BACKLOG = 64;
   localparam int PHASE_BYTES = 65;

   typedef enum logic {
      IN_LENGTH,
      IN_PAYLOAD
   } parse_phase_type;

   typedef enum int {
      WELL_FORMED,
      LENGTH_OVERRUN,
      CUT_IN_PREFIX,
      RANDOM_BYTES,
      ZERO_LENGTH_PACKET
   } packet_shape_type;

   // One input transaction plus the number of idle cycles the driver leaves before it.
   typedef struct packed {
      logic [7:0]            gap;
      logic [DATA_WIDTH-1:0] data;
      logic [PLEN_WIDTH-1:0] plen;
   } stream_byte_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  out_byte;
      logic                   byte_valid;
      logic                   packet_end;
      logic                   packet_error;
      logic [COUNT_WIDTH-1:0] output_count;
   } annexb_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [DATA_WIDTH-1:0]  req_data_byte = '0;
   logic [PLEN_WIDTH-1:0]  req_packet_length = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0]  rsp_out_byte;
   logic                   rsp_byte_valid;
   logic                   rsp_packet_end;
   logic                   rsp_packet_error;
   logic [COUNT_WIDTH-1:0] rsp_output_count;

   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   length_prefixed_nal_to_annexb_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_packet_length(req_packet_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_packet_error (rsp_packet_error),
      .rsp_output_count (rsp_output_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bytes waiting to be offered, and the Annex B results expected back, oldest first.
   stream_byte_type   pending_bytes[$];
   annexb_result_type annexb_expected[$];
   // Scratch buffer in which the stimulus builds one packet before queueing it.
   logic [7:0]     frame[$];

   // The converter's state as the checker sees it, following every accepted byte.
   logic [LFB_WIDTH-1:0]   lfb_setting = LFB_RESET;
   parse_phase_type        nal_phase = IN_LENGTH;
   logic [ACC_WIDTH-1:0]   len_acc = '0;
   logic [2:0]             len_seen = '0;
   logic [PLEN_WIDTH-1:0]  payload_left = '0;
   logic [PLEN_WIDTH-1:0]  taken = '0;
   logic [PLEN_WIDTH-1:0]  pkt_total = '0;
   logic [COUNT_WIDTH-1:0] emitted = '0;
   logic                   pkt_bad = 1'b0;

   int error_count = 0;
   int results_checked = 0;
   int bytes_taken = 0;
   int packets_closed = 0;
   int packets_flagged = 0;

   task automatic flag_error(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic expect_result(input logic [7:0] b, input logic v, input logic e,
                                input logic err, input logic [COUNT_WIDTH-1:0] cnt);
      annexb_result_type r;
      r.out_byte = b;
      r.byte_valid = v;
      r.packet_end = e;
      r.packet_error = err;
      r.output_count = cnt;
      annexb_expected.push_back(r);
   endtask

   task automatic count_emitted();
      if (emitted != '1)
         emitted++;
   endtask

   // Works out what one accepted byte produces and queues those results.
   task automatic convert_byte(input logic [DATA_WIDTH-1:0] b,
                               input logic [PLEN_WIDTH-1:0] plen_in);
      logic [PLEN_WIDTH-1:0] plen;
      logic [ACC_WIDTH-1:0]  nal_len;
      logic [PLEN_WIDTH-1:0] left;
      plen = plen_in;
      // The packet length is only looked at on the first byte; zero counts as one byte.
      if (taken == 0) begin
         if (plen == 0)
            plen = 1;
         pkt_total = plen;
         nal_phase = IN_LENGTH;
         len_acc = '0;
         len_seen = '0;
         payload_left = '0;
         emitted = '0;
         pkt_bad = (plen > MAX_PACKET_BYTES);
      end
      if (lfb_setting < 1 || lfb_setting > LFB_MAX)
         pkt_bad = 1'b1;
      if (taken < pkt_total)
         taken++;
      if (!pkt_bad) begin
         if (nal_phase == IN_PAYLOAD) begin
            expect_result(b, 1'b1, 1'b0, 1'b0, '0);
            count_emitted();
            if (payload_left > 0)
               payload_left--;
            if (payload_left == 0)
               nal_phase = IN_LENGTH;
         end else begin
            len_acc = {len_acc[ACC_WIDTH-9:0], b};
            if (len_seen < 7)
               len_seen++;
            if (len_seen >= lfb_setting) begin
               nal_len = len_acc;
               left = pkt_total - taken;
               len_acc = '0;
               len_seen = '0;
               // A zero length field is skipped without a start code.
               if (nal_len != 0) begin
                  if (nal_len > ACC_WIDTH'(left)) begin
                     pkt_bad = 1'b1;
                  end else begin
                     for (int i = 0; i < 4; i++) begin
                        expect_result(8'(START_CODE >> (8 * i)), 1'b1, 1'b0, 1'b0, '0);
                        count_emitted();
                     end
                     payload_left = nal_len[PLEN_WIDTH-1:0];
                     nal_phase = IN_PAYLOAD;
                  end
               end
            end
         end
      end
      if (taken >= pkt_total) begin
         // Running out of bytes halfway through a length field is a malformed packet.
         if (!pkt_bad && nal_phase == IN_LENGTH && len_seen != 0)
            pkt_bad = 1'b1;
         expect_result('0, 1'b0, 1'b1, pkt_bad, emitted);
         packets_closed++;
         if (pkt_bad)
            packets_flagged++;
         nal_phase = IN_LENGTH;
         len_acc = '0;
         len_seen = '0;
         payload_left = '0;
         taken = '0;
         pkt_total = '0;
         emitted = '0;
         pkt_bad = 1'b0;
      end
   endtask

   // Idle cycles before a transaction: mostly a few, now and then a long pause; never none.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Driver: offers the head of pending_bytes once its gap has elapsed and keeps it
   // steady until the unit takes it. Every accepted transaction goes to the predictor.
   stream_byte_type offered;
   int              idle_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_done <= 0;
      end else begin
         if (req_valid && req_ready) begin
            convert_byte(offered.data, offered.plen);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && idle_done >= int'(pending_bytes[0].gap)) begin
               offered = pending_bytes.pop_front();
               req_data_byte <= offered.data;
               req_packet_length <= offered.plen;
               req_valid <= 1'b1;
               idle_done <= 0;
            end else begin
               req_valid <= 1'b0;
               if (pending_bytes.size() != 0)
                  idle_done <= idle_done + 1;
            end
         end
      end
   end

   // Receiver: random stalls with calm stretches in between, plus one long hold-off that
   // fills the unit up while the driver keeps offering bytes.
   int   stall_left = 0;
   int   calm_left = 0;
   logic long_hold_done = 1'b0;
   logic ready_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         calm_left <= 0;
      end else if (!long_hold_done && bytes_taken >= HOLD_AFTER) begin
         long_hold_done <= 1'b1;
         stall_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else begin
         ready_next = 1'b1;
         if (calm_left != 0) begin
            calm_left <= calm_left - 1;
         end else if ($urandom_range(0, 49) == 0) begin
            calm_left <= $urandom_range(40, 160);
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= idle_length();
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   // Monitor: every accepted result must match the oldest expectation field by field.
   annexb_result_type want;

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp);
      if (got !== exp)
         flag_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (annexb_expected.size() == 0) begin
            flag_error($sformatf("unexpected result byte 0x%0h end %0b", rsp_out_byte,
                                 rsp_packet_end));
         end else begin
            want = annexb_expected.pop_front();
            check_field("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
            check_field("byte_valid", 32'(rsp_byte_valid), 32'(want.byte_valid));
            check_field("packet_end", 32'(rsp_packet_end), 32'(want.packet_end));
            check_field("packet_error", 32'(rsp_packet_error), 32'(want.packet_error));
            check_field("output_count", 32'(rsp_output_count), 32'(want.output_count));
            results_checked++;
         end
      end
   end

   // One APB transaction to the length_field_bytes register; rdata is taken at the
   // completing edge.
   task automatic csr_access(input logic write, input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= LFB_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes the prefix size, mirrors it in the predictor and reads it back.
   task automatic set_prefix_size(input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b1, value, rd);
      lfb_setting = value[LFB_WIDTH-1:0];
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DW'(lfb_setting))
         flag_error($sformatf("length_field_bytes reads 0x%0h, expected %0d", rd, lfb_setting));
   endtask

   // Waits until the unit has nothing left to do, so a register write is safe.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || annexb_expected.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic [PLEN_WIDTH-1:0] plen,
                             input int gap);
      stream_byte_type item;
      while (pending_bytes.size() >= BACKLOG)
         @(posedge clock);
      item.gap = 8'(gap);
      item.data = data;
      item.plen = plen;
      pending_bytes.push_back(item);
   endtask

   // Queues the packet in frame. Only its first byte carries the real length; the
   // length port is don't-care after that and gets random values.
   task automatic send_frame(input logic [PLEN_WIDTH-1:0] first_plen, input logic calm);
      int gap;
      for (int i = 0; i < frame.size(); i++) begin
         if (calm || $urandom_range(0, 99) < 65)
            gap = 0;
         else
            gap = idle_length();
         queue_byte(frame[i], (i == 0) ? first_plen : PLEN_WIDTH'($urandom), gap);
      end
      frame.delete();
   endtask

   task automatic add_nal(input int size, input int lfb);
      for (int k = lfb - 1; k >= 0; k--)
         frame.push_back(8'(size >> (8 * k)));
      repeat (size) frame.push_back(8'($urandom));
   endtask

   task automatic add_good_nals(input int count, input int lfb);
      int size;
      repeat (count) begin
         if ($urandom_range(0, 5) == 0)
            size = 0;
         else if ($urandom_range(0, 9) == 0)
            size = $urandom_range(13, 60);
         else
            size = $urandom_range(1, 12);
         add_nal(size, lfb);
      end
   endtask

   // Builds one packet of the given shape for a prefix of lfb bytes and queues it.
   task automatic add_packet(input packet_shape_type shape, input int lfb);
      logic [63:0] field_max;
      logic [63:0] size;
      int          tail;
      logic        calm;
      calm = ($urandom_range(0, 4) == 0);
      case (shape)
         WELL_FORMED: begin
            add_good_nals($urandom_range(1, 4), lfb);
         end
         LENGTH_OVERRUN: begin
            // A length field that claims more bytes than the packet still holds.
            add_good_nals($urandom_range(0, 2), lfb);
            tail = $urandom_range(0, 6);
            field_max = (64'd1 << (8 * lfb)) - 1;
            if ($urandom_range(0, 2) == 0)
               size = field_max;
            else
               size = 64'(tail + 1 + $urandom_range(0, 3));
            for (int k = lfb - 1; k >= 0; k--)
               frame.push_back(8'(size >> (8 * k)));
            repeat (tail) frame.push_back(8'($urandom));
         end
         CUT_IN_PREFIX: begin
            // If lfb > 1, the packet ends inside a length field, possibly the first one.
            add_good_nals($urandom_range(0, 2), lfb);
            if (lfb > 1)
               repeat ($urandom_range(1, lfb - 1)) frame.push_back(8'($urandom));
         end
         RANDOM_BYTES: begin
            repeat ($urandom_range(1, 16)) frame.push_back(8'($urandom));
         end
         default: begin
            // Declared length of zero: the unit treats it as a one-byte packet.
            frame.push_back(8'($urandom));
            send_frame('0, calm);
         end
      endcase
      if (frame.size() != 0)
         send_frame(PLEN_WIDTH'(frame.size()), calm);
   endtask

   function automatic packet_shape_type pick_shape();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return WELL_FORMED;
      if (r < 80)
         return LENGTH_OVERRUN;
      if (r < 88)
         return CUT_IN_PREFIX;
      if (r < 95)
         return RANDOM_BYTES;
      return ZERO_LENGTH_PACKET;
   endfunction

   // Prefix sizes for the random phases; 5 is out of range and turns every packet into
   // an error.
   int lfb_plan[8] = '{1, 3, 2, 4, 5, 1, 2, 4};

   initial begin
      int start_count;
      int lfb;
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed packets with the reset prefix size of four bytes. The reset value is
      // written back once so that the register sees a write in this setting too.
      set_prefix_size(32'd4);
      frame = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF};
      send_frame(PLEN_WIDTH'(6), 1'b1);
      // A zero length field that closes the packet is not an error.
      frame = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_frame(PLEN_WIDTH'(4), 1'b0);
      // Zero declared length: one byte, shorter than a single length field.
      frame = '{8'hA5};
      send_frame('0, 1'b0);
      // Largest possible length against one remaining byte.
      frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E};
      send_frame(PLEN_WIDTH'(5), 1'b1);
      wait_idle();

      // Both ends of the register that lie outside 1..4 make the whole packet bad.
      set_prefix_size(32'd0);
      frame = '{8'h12, 8'h34};
      send_frame(PLEN_WIDTH'(2), 1'b0);
      wait_idle();
      set_prefix_size(32'd7);
      frame = '{8'h00, 8'h01};
      send_frame(PLEN_WIDTH'(2), 1'b1);
      wait_idle();

      // Random phases, each with its own prefix size. Upper write-data bits are junk
      // that the register must ignore.
      for (int p = 0; p < 8; p++) begin
         set_prefix_size({29'($urandom), 3'(lfb_plan[p])});
         lfb = (lfb_plan[p] >= 1 && lfb_plan[p] <= 4) ? lfb_plan[p] : 4;
         target = (lfb_plan[p] == lfb) ? PHASE_BYTES : 15;
         start_count = bytes_taken + pending_bytes.size();
         while (bytes_taken + pending_bytes.size() - start_count < target)
            add_packet(pick_shape(), lfb);
         wait_idle();
      end

      // A last packet with the reset prefix size.
      set_prefix_size(32'd4);
      add_packet(WELL_FORMED, 4);

      wait_idle();
      repeat (4 * IDLE_SETTLE) @(posedge clock);
      if (annexb_expected.size() != 0)
         flag_error($sformatf("%0d results never arrived", annexb_expected.size()));

      $display("Run covered %0d input bytes in %0d packets (%0d malformed), %0d results checked,",
               bytes_taken, packets_closed, packets_flagged, results_checked);
      $display("with prefix sizes 1 to 4, out-of-range sizes and a long receiver hold-off.");
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Safety net: a run that never finishes is ended and reported as failed.
   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule
